// File: rtl/kmc_pkg.sv
`timescale 1ns / 1ps

package kmc_pkg;

	// fixed field widths
	localparam int WORD_CODE_W = 12;
	localparam int COUNT_W     = 24;
	localparam int SUM_W       = 29;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OWN,
		ST_NEIGH
	} seq_state_t;

	// control that travels with each table access
	typedef struct packed {
		logic vld;   // access present
		logic wr;    // table write (else read)
		logic own;   // access to the item's own word
		logic last;  // final access of the item
	} req_t;

endpackage

// File: rtl/kmc_seq.sv
`timescale 1ns / 1ps

module kmc_seq import kmc_pkg::*; #(
	parameter int WORD_LEN = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic [WORD_CODE_W-1:0]   word_code,
	input  logic [COUNT_W-1:0]       count_value,
	input  logic                     res_load,
	input  logic                     res_free,
	output req_t                     req,
	output logic [2*WORD_LEN-1:0]    code,
	output logic [COUNT_W-1:0]       wdata,
	output logic [WORD_CODE_W-1:0]   query_word
);

	localparam int CODE_W = 2 * WORD_LEN;
	localparam int POS_W  = $clog2(WORD_LEN);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(WORD_LEN - 1);

	seq_state_t             state_q, state_d;
	op_t                    op_q;
	logic [CODE_W-1:0]      code_q;
	logic [COUNT_W-1:0]     wdata_q;
	logic [POS_W-1:0]       pos_q;
	logic [1:0]             k_q;
	logic                   pend_q;
	logic                   accept;
	logic                   last_nb;
	logic [1:0]             digit, nbase;
	logic [CODE_W-1:0]      flip;

	assign accept  = in_valid && !in_stall;
	assign last_nb = (pos_q == LAST_POS) && (k_q == 2'd3);

	// neighbour: replace the digit at pos_q by digit + k (mod 4)
	always_comb begin
		digit = 2'(code_q >> {pos_q, 1'b0});
		nbase = digit + k_q;
		flip  = CODE_W'(digit ^ nbase) << {pos_q, 1'b0};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_d = ST_OWN;
			ST_OWN: begin
				// a query starts only once the result slot is free
				if (op_q == OP_WRITE) state_d = ST_IDLE;
				else if (res_free) state_d = ST_NEIGH;
			end
			ST_NEIGH: if (last_nb) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req      = '0;
		code     = code_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = pend_q;
			end
			ST_OWN: begin
				req.vld  = (op_q == OP_WRITE) || res_free;
				req.wr   = (op_q == OP_WRITE);
				req.own  = 1'b1;
				req.last = (op_q == OP_WRITE);
			end
			ST_NEIGH: begin
				req.vld  = 1'b1;
				req.last = last_nb;
				code     = code_q ^ flip;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign wdata      = wdata_q;
	assign query_word = WORD_CODE_W'(code_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
			pos_q   <= '0;
			k_q     <= 2'd1;
		end else begin
			state_q <= state_d;
			if (accept && op_t'(opcode) == OP_QUERY) pend_q <= 1'b1;
			else if (res_load) pend_q <= 1'b0;
			if (state_q == ST_NEIGH) begin
				if (k_q == 2'd3) begin
					k_q   <= 2'd1;
					pos_q <= last_nb ? '0 : pos_q + 1'b1;
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(opcode);
			code_q  <= CODE_W'(word_code);
			wdata_q <= count_value;
		end
	end

endmodule

// File: rtl/kmc_mod.sv
`timescale 1ns / 1ps

// code % TABLE_DEPTH by reciprocal multiply, three stages
module kmc_mod import kmc_pkg::*; #(
	parameter int WORD_LEN    = 6,
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  req_t                           req,
	input  logic [2*WORD_LEN-1:0]          code,
	input  logic [COUNT_W-1:0]             wdata,
	output req_t                           req_s3,
	output logic [$clog2(TABLE_DEPTH)-1:0] addr_s3,
	output logic [COUNT_W-1:0]             wdata_s3
);

	localparam int CODE_W  = 2 * WORD_LEN;
	localparam int ADDR_W  = $clog2(TABLE_DEPTH);
	localparam int RW      = ADDR_W + 1;
	localparam int RECIP_W = CODE_W + 1;
	localparam int PROD_W  = 2 * CODE_W + 1;
	localparam int QD_W    = CODE_W + RW + 1;
	localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << CODE_W) / TABLE_DEPTH);
	localparam logic [RW-1:0]      DEPTH_C = RW'(TABLE_DEPTH);

	req_t                 req_s1, req_s2;
	logic [CODE_W-1:0]    x_s1, x_s2;
	logic [PROD_W-1:0]    prod_s1;
	logic [CODE_W-1:0]    qd_s2;
	logic [COUNT_W-1:0]   wdata_s1, wdata_s2;
	logic [CODE_W:0]      quot;
	logic [QD_W-1:0]      qd_full;
	logic [CODE_W-1:0]    diff;
	logic [RW-1:0]        rem;
	logic [RW-1:0]        rem_fix;

	// quotient estimate is exact or one low
	always_comb begin
		quot    = prod_s1[PROD_W-1:CODE_W];
		qd_full = QD_W'(quot) * QD_W'(TABLE_DEPTH);
		diff    = x_s2 - qd_s2;
		rem     = RW'(diff);
		rem_fix = (rem >= DEPTH_C) ? rem - DEPTH_C : rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
			req_s2 <= '0;
			req_s3 <= '0;
		end else begin
			req_s1 <= req;
			req_s2 <= req_s1;
			req_s3 <= req_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1     <= code;
		prod_s1  <= PROD_W'(code) * PROD_W'(RECIP);
		wdata_s1 <= wdata;
		x_s2     <= x_s1;
		qd_s2    <= qd_full[CODE_W-1:0];
		wdata_s2 <= wdata_s1;
		addr_s3  <= ADDR_W'(rem_fix);
		wdata_s3 <= wdata_s2;
	end

endmodule

// File: rtl/kmc_table.sv
`timescale 1ns / 1ps

module kmc_table import kmc_pkg::*; #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  req_t                           req_s3,
	input  logic [$clog2(TABLE_DEPTH)-1:0] addr_s3,
	input  logic [COUNT_W-1:0]             wdata_s3,
	output req_t                           req_s4,
	output logic [COUNT_W-1:0]             rdata_s4
);

	logic [COUNT_W-1:0] mem [TABLE_DEPTH];

	// single port: one write or one read per cycle
	always_ff @(posedge clk) begin
		if (req_s3.vld) begin
			if (req_s3.wr) begin
				mem[addr_s3] <= wdata_s3;
			end else begin
				rdata_s4 <= mem[addr_s3];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s4 <= '0;
		end else begin
			req_s4 <= req_s3;
		end
	end

endmodule

// File: rtl/kmer_one_mismatch_count.sv
`timescale 1ns / 1ps

// Channel  Signals                                   Transfer when
// -------  ----------------------------------------  --------------------------
// in       in_valid, in_stall, opcode,               in_valid && !in_stall
//          word_code, count_value
// out      out_valid, out_stall, queried_word,       out_valid && !out_stall
//          weighted_quarters
//
// A write issues its table access from ST_OWN, then the next item can be taken.
// A query issues 19 (1 + 3*WORD_LEN) accesses to the single-port count table,
// one per cycle, which pass the address reduction and table read registers
// before the result register loads; the next item is taken once it has loaded.
// A query holds its first access while an earlier result waits under out_stall.
// Reset clears control only.
module kmer_one_mismatch_count import kmc_pkg::*; #(
	parameter int WORD_LEN    = 6,
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   opcode,
	input  logic [WORD_CODE_W-1:0] word_code,
	input  logic [COUNT_W-1:0]     count_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [WORD_CODE_W-1:0] queried_word,
	output logic [SUM_W-1:0]       weighted_quarters
);

	localparam int CODE_W = 2 * WORD_LEN;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);

	req_t                   req, req_s3, req_s4;
	logic [CODE_W-1:0]      code;
	logic [COUNT_W-1:0]     wdata, wdata_s3, rdata_s4;
	logic [ADDR_W-1:0]      addr_s3;
	logic [WORD_CODE_W-1:0] query_word;
	logic                   out_done;
	logic                   res_load;
	logic                   res_free;
	logic                   out_valid_q;
	logic [WORD_CODE_W-1:0] out_word_q;
	logic [SUM_W-1:0]       sum_q, out_sum_q;
	logic [SUM_W-1:0]       term, sum_next;
	logic                   rd_hit;

	// sequencer: takes the item, walks own word then every one-base neighbour
	kmc_seq #(
		.WORD_LEN (WORD_LEN)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.word_code   (word_code),
		.count_value (count_value),
		.res_load    (res_load),
		.res_free    (res_free),
		.req         (req),
		.code        (code),
		.wdata       (wdata),
		.query_word  (query_word)
	);

	// word code wraps into the table depth
	kmc_mod #(
		.WORD_LEN    (WORD_LEN),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.code     (code),
		.wdata    (wdata),
		.req_s3   (req_s3),
		.addr_s3  (addr_s3),
		.wdata_s3 (wdata_s3)
	);

	kmc_table #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_s3   (req_s3),
		.addr_s3  (addr_s3),
		.wdata_s3 (wdata_s3),
		.req_s4   (req_s4),
		.rdata_s4 (rdata_s4)
	);

	assign out_done = out_valid_q && !out_stall;
	assign rd_hit   = req_s4.vld && !req_s4.wr;
	assign res_load = rd_hit && req_s4.last;
	assign res_free = !out_valid_q || out_done;

	// own count weighs four quarters, each neighbour one quarter
	always_comb begin
		term     = req_s4.own ? SUM_W'({rdata_s4, 2'b00}) : SUM_W'(rdata_s4);
		sum_next = req_s4.own ? term : sum_q + term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			// seq starts a query only with the result slot free, so a load never hits a full slot
			if (res_load) out_valid_q <= 1'b1;
			else if (out_done) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_hit) begin
			sum_q <= sum_next;
			if (req_s4.last) begin
				out_sum_q  <= sum_next;
				out_word_q <= query_word;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign queried_word      = out_word_q;
	assign weighted_quarters = out_sum_q;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

// Mismatch-weighted k-mer count table.
// A write stores a 24-bit count at its word code. A query gets back
// 4*own count plus the counts of all 18 one-base neighbours.
// A shadow table in the bench predicts every query result at its input transfer.
// A bitmap tracks which entries hold a count. A query is only issued once its
// whole neighborhood has been written, because unwritten entries read as X.
module tb;
	import kmc_pkg::*;

	localparam int WORD_LEN      = 6;
	localparam int TABLE_DEPTH   = 4096;
	localparam int HOOD_SIZE     = 1 + 3 * WORD_LEN;   // own entry + neighbours
	localparam int ITEMS_TARGET  = 800;
	localparam int QUERY_FLOOR   = 48;                 // keep going until this many queries
	localparam int HOLD_CYCLES   = 300;                // long receiver hold-off
	localparam int DRAIN_CYCLES  = 40;                 // settle wait after the last result
	localparam int WATCHDOG_LIM  = 4000;               // cycles with no transfer at all

	typedef struct {
		logic [WORD_CODE_W-1:0] word;
		logic [SUM_W-1:0]       quarters;
	} query_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   opcode = 1'b0;
	logic [WORD_CODE_W-1:0] word_code = '0;
	logic [COUNT_W-1:0]     count_value = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [WORD_CODE_W-1:0] queried_word;
	logic [SUM_W-1:0]       weighted_quarters;

	// shadow of the count table and its written-entry map
	logic [COUNT_W-1:0]     count_shadow [TABLE_DEPTH];
	bit                     entry_written [TABLE_DEPTH];
	logic [WORD_CODE_W-1:0] written_words[$];

	query_result_t          pending_queries[$];

	int err_count    = 0;
	int items_sent   = 0;
	int queries_sent = 0;

	// sender burst shaping
	bit gaps_on    = 1'b1;
	int burst_left = 0;

	// receiver stall pattern and the hold-off request
	int hold_gen      = 0;
	int hold_gen_seen = 0;
	int hold_left     = 0;
	int stall_mode    = 0;
	int mode_left     = 0;
	bit stall_phase   = 1'b0;

	int idle_cycles = 0;

	kmer_one_mismatch_count #(
		.WORD_LEN   (WORD_LEN),
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.opcode           (opcode),
		.word_code        (word_code),
		.count_value      (count_value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.queried_word     (queried_word),
		.weighted_quarters(weighted_quarters)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Member idx of the neighborhood of code: 0 is the word itself; 1..18 walk
	// the positions from the last base up, three substitute bases each,
	// skipping the base already there.
	function automatic logic [WORD_CODE_W-1:0] hood_member(input logic [WORD_CODE_W-1:0] code,
		input int idx);
		int pos;
		int k;
		logic [1:0] own_base;
		logic [WORD_CODE_W-1:0] nb;
		nb = code;
		if (idx > 0) begin
			pos = (idx - 1) / 3;
			k = (idx - 1) % 3;
			own_base = code[2*pos +: 2];
			nb[2*pos +: 2] = (k < own_base) ? 2'(k) : 2'(k + 1);
		end
		return nb;
	endfunction

	// Quarter-unit weighted count: own entry four times, each neighbour once.
	function automatic logic [SUM_W-1:0] mismatch_weighted_sum(input logic [WORD_CODE_W-1:0] code);
		logic [SUM_W+3:0] acc;
		int idx;
		acc = {7'b0, count_shadow[code], 2'b00};
		for (idx = 1; idx < HOOD_SIZE; idx++)
			acc += (SUM_W+4)'(count_shadow[hood_member(code, idx)]);
		return acc[SUM_W-1:0];
	endfunction

	function automatic bit hood_ready(input logic [WORD_CODE_W-1:0] code);
		int idx;
		for (idx = 0; idx < HOOD_SIZE; idx++)
			if (!entry_written[hood_member(code, idx)])
				return 1'b0;
		return 1'b1;
	endfunction

	// counts lean on the extremes now and then
	function automatic logic [COUNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return COUNT_W'($urandom());
	endfunction

	// One input transfer. Valid stays high across back-to-back items; a gap
	// lowers it in one step and raises it in a later one.
	task automatic send_item(input op_t op, input logic [WORD_CODE_W-1:0] code,
		input logic [COUNT_W-1:0] cnt);
		int gap;
		if (gaps_on) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) :
					$urandom_range(1, 24);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left--;
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		word_code   <= code;
		count_value <= cnt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// transfer happened at this edge: update the shadow in item order
		items_sent++;
		if (op == OP_WRITE) begin
			if (!entry_written[code])
				written_words.push_back(code);
			entry_written[code] = 1'b1;
			count_shadow[code] = cnt;
		end else begin
			queries_sent++;
			pending_queries.push_back('{word: code, quarters: mismatch_weighted_sum(code)});
		end
	endtask

	// fill whatever the query would read that has no count yet, then query
	task automatic query_with_fill(input logic [WORD_CODE_W-1:0] code);
		int idx;
		logic [WORD_CODE_W-1:0] nb;
		for (idx = 0; idx < HOOD_SIZE; idx++) begin
			nb = hood_member(code, idx);
			if (!entry_written[nb])
				send_item(OP_WRITE, nb, pick_count());
		end
		send_item(OP_QUERY, code, COUNT_W'($urandom()));
	endtask

	// drop valid, let every expected result come home, then allow the latency
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_queries.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Word 0 with its full neighborhood at the largest count gives the largest
	// sum; clearing the own entry then checks the neighbours' sum on its own.
	task automatic test_extreme_counts();
		int idx;
		for (idx = 0; idx < HOOD_SIZE; idx++)
			send_item(OP_WRITE, hood_member('0, idx), '1);
		send_item(OP_QUERY, '0, '1);
		send_item(OP_WRITE, '0, '0);
		send_item(OP_QUERY, '0, '0);
	endtask

	// Receiver holds off for a long stretch while items keep coming with no
	// gaps, so the result register fills and in_stall must rise.
	task automatic test_backpressure();
		int n;
		gaps_on = 1'b0;
		hold_gen <= hold_gen + 1;
		for (n = 0; n < 12; n++) begin
			if (n % 3 == 2)
				send_item(OP_WRITE, hood_member('0, $urandom_range(0, HOOD_SIZE - 1)),
					pick_count());
			else
				send_item(OP_QUERY, '0, COUNT_W'($urandom()));
		end
		gaps_on = 1'b1;
	endtask

	// Mostly well-formed traffic: fill a neighborhood, then query it. The rest
	// rewrites known entries, re-queries ready words, or scatters stray writes
	// that leave neighborhoods half done.
	task automatic test_random_traffic();
		int r;
		logic [WORD_CODE_W-1:0] target;
		logic [WORD_CODE_W-1:0] last_target;
		last_target = '0;
		while (items_sent < ITEMS_TARGET || queries_sent < QUERY_FLOOR) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				r = $urandom_range(0, 99);
				if (r < 12) begin
					case ($urandom_range(0, 3))
						0: target = '0;
						1: target = '1;
						2: target = 12'hAAA;
						default: target = 12'h555;
					endcase
				end else if (r < 45) begin
					target = hood_member(last_target, $urandom_range(1, HOOD_SIZE - 1));
				end else begin
					target = WORD_CODE_W'($urandom());
				end
				query_with_fill(target);
				last_target = target;
			end else if (r < 70) begin
				target = written_words[$urandom_range(0, written_words.size() - 1)];
				send_item(OP_WRITE, target, pick_count());
			end else if (r < 90) begin
				target = written_words[$urandom_range(0, written_words.size() - 1)];
				if (hood_ready(target))
					send_item(OP_QUERY, target, COUNT_W'($urandom()));
				else
					query_with_fill(target);
			end else begin
				send_item(OP_WRITE, WORD_CODE_W'($urandom()), pick_count());
			end
		end
	endtask

	// Receiver: a hold-off request wins; otherwise it switches at random among
	// modes - no stall, light random, heavy random, alternating.
	always @(posedge clk) begin
		if (hold_gen != hold_gen_seen) begin
			hold_gen_seen = hold_gen;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			stall_phase = ~stall_phase;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 9) < 3);
				2: out_stall <= ($urandom_range(0, 9) < 7);
				default: out_stall <= stall_phase;
			endcase
		end
	end

	// result checker: each output transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_queries.size() == 0) begin
				$error("unexpected result: queried_word %0h, weighted_quarters %0d",
					queried_word, weighted_quarters);
				err_count++;
			end else begin
				if (queried_word !== pending_queries[0].word) begin
					$error("queried_word: expected %0h, got %0h",
						pending_queries[0].word, queried_word);
					err_count++;
				end
				if (weighted_quarters !== pending_queries[0].quarters) begin
					$error("weighted_quarters: expected %0d, got %0d",
						pending_queries[0].quarters, weighted_quarters);
					err_count++;
				end
				void'(pending_queries.pop_front());
			end
		end
	end

	// watchdog: too long with no transfer on either side means a hang
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIM) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extreme_counts();
		settle();
		test_backpressure();
		settle();
		test_random_traffic();
		settle();

		if (err_count == 0 && pending_queries.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
